### sv/binary_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// Binary to decimal ASCII assertion macros
// Concurrent check wrappers on clk_i / rst_ni; ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef ASSERT_OFF
`define BDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BDA_ASSERT(lbl, prop, msg)
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, character codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int ValueW    = 64;
  localparam int NumDigits = 20;
  localparam int DigitW    = 4;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int IdxW      = $clog2(NumDigits);
  localparam int CntW      = $clog2(ValueW);
  localparam int CharW     = 6;
  localparam int TdataOutW = 8;

  localparam logic [CharW-1:0] CharZero  = 6'd48;
  localparam logic [CharW-1:0] CharNine  = 6'd57;
  localparam logic [CharW-1:0] CharMinus = 6'd45;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic idx_dec;
    logic emit_sign;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic idx_zero;
    logic neg;
    logic out_free;
  } dp_status_t;

endpackage

### sv/bda_datapath.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII datapath
// Magnitude load, bit-serial double dabble, digit select and output register.
// ----------------------------------------------------------------------------
module bda_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bda_pkg::ctrl_cmd_t              cmd_i,
  output bda_pkg::dp_status_t             status_o,
  input  logic                            kind_i,
  input  logic [bda_pkg::ValueW-1:0]      value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bda_pkg::CharW-1:0]       char_code_o,
  output logic                            last_char_o
);

  logic [bda_pkg::ValueW-1:0]                        bin_q, bin_d;
  logic [bda_pkg::NumDigits-1:0][bda_pkg::DigitW-1:0] bcd_q, bcd_d, adj;
  logic [bda_pkg::BcdW-1:0]                          adj_flat;
  logic                                              neg_q, neg_d;
  logic [bda_pkg::IdxW-1:0]                          idx_q, idx_d;
  logic [bda_pkg::CntW-1:0]                          cnt_q, cnt_d;
  logic                                              valid_q, valid_d;
  logic [bda_pkg::CharW-1:0]                         char_q, char_d;
  logic                                              last_q, last_d;
  logic [bda_pkg::DigitW-1:0]                        cur_digit;
  logic                                              load_neg;

  assign load_neg  = kind_i & value_i[bda_pkg::ValueW-1];
  assign cur_digit = bcd_q[idx_q];

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < bda_pkg::NumDigits; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end
  assign adj_flat = adj;

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    valid_d = valid_q & ~out_ready_i;
    char_d  = char_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      neg_d = load_neg;
      bin_d = load_neg ? (~value_i + bda_pkg::ValueW'(1)) : value_i;
      bcd_d = '0;
      idx_d = bda_pkg::IdxW'(bda_pkg::NumDigits - 1);
      cnt_d = '0;
    end
    if (cmd_i.shift) begin
      bcd_d = {adj_flat[bda_pkg::BcdW-2:0], bin_q[bda_pkg::ValueW-1]};
      bin_d = {bin_q[bda_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q + bda_pkg::CntW'(1);
    end
    if (cmd_i.idx_dec) begin
      idx_d = idx_q - bda_pkg::IdxW'(1);
    end
    if (cmd_i.emit_sign) begin
      valid_d = 1'b1;
      char_d  = bda_pkg::CharMinus;
      last_d  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      valid_d = 1'b1;
      char_d  = bda_pkg::CharZero + bda_pkg::CharW'(cur_digit);
      last_d  = (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.conv_done = (cnt_q == '1);
  assign status_o.idx_zero  = (idx_q == '0);
  assign status_o.lead_zero = (idx_q != '0) && (cur_digit == '0);
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = ~valid_q | out_ready_i;

  assign out_valid_o = valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

### sv/bda_ctrl.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII controller
// Sequences load, conversion, leading zero scan and character emission.
// ----------------------------------------------------------------------------
module bda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bda_pkg::dp_status_t  status_i,
  output bda_pkg::ctrl_cmd_t   cmd_o
);

  bda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bda_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bda_pkg::StIdle: begin
        if (in_valid_i) state_d = bda_pkg::StConv;
      end
      bda_pkg::StConv: begin
        if (status_i.conv_done) state_d = bda_pkg::StSkip;
      end
      bda_pkg::StSkip: begin
        if (!status_i.lead_zero) begin
          state_d = status_i.neg ? bda_pkg::StSign : bda_pkg::StDigit;
        end
      end
      bda_pkg::StSign: begin
        if (status_i.out_free) state_d = bda_pkg::StDigit;
      end
      bda_pkg::StDigit: begin
        if (status_i.out_free && status_i.idx_zero) state_d = bda_pkg::StIdle;
      end
      default: state_d = bda_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bda_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bda_pkg::StConv: begin
        cmd_o.shift = 1'b1;
      end
      bda_pkg::StSkip: begin
        cmd_o.idx_dec = status_i.lead_zero;
      end
      bda_pkg::StSign: begin
        cmd_o.emit_sign = status_i.out_free;
      end
      bda_pkg::StDigit: begin
        cmd_o.emit_digit = status_i.out_free;
        cmd_o.idx_dec    = status_i.out_free & ~status_i.idx_zero;
      end
      default: ;
    endcase
  end

endmodule

### sv/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter, top level
// Turns a 64-bit word into its decimal text, one ASCII character per request.
// ----------------------------------------------------------------------------
// Slave stream: tdata carries the value, tuser the kind (1: two's complement).
// Master stream: one request per character, most significant digit first,
// '-' ahead of a negative signed value; tlast marks the final character.
// An item is taken only while idle. After the accept cycle the magnitude runs
// through a bit-serial double dabble, one bit per cycle through the BCD shift
// register. A leading zero scan then steps down from the top digit, and
// characters follow at one per cycle while the receiver takes them. The next
// value is taken only after the last character of this one has been emitted.
// The last character sits in an output register, so the next value may be
// accepted while it waits. A stalled receiver holds the current character
// and pauses emission. Reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bda_pkg::ValueW-1:0]      s_axis_tdata,   // [63:0] value
  input  logic                            s_axis_tuser,   // [0] kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bda_pkg::TdataOutW-1:0]   m_axis_tdata,   // [5:0] char_code, [7:6] zero
  output logic                            m_axis_tlast    // last_char
);

  bda_pkg::ctrl_cmd_t        cmd;
  bda_pkg::dp_status_t       status;
  logic [bda_pkg::CharW-1:0] char_code;
  logic                      in_accept;
  logic                      char_ok;
  logic                      sign_out;
  logic [3:0]                cmd_bits;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bda_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .char_code_o (char_code),
    .last_char_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(bda_pkg::TdataOutW - bda_pkg::CharW){1'b0}}, char_code};

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign char_ok   = (char_code == bda_pkg::CharMinus) ||
                     ((char_code >= bda_pkg::CharZero) && (char_code <= bda_pkg::CharNine));
  assign sign_out  = m_axis_tvalid && (char_code == bda_pkg::CharMinus);
  assign cmd_bits  = {cmd.load, cmd.shift, cmd.emit_sign, cmd.emit_digit};

  `BDA_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready, "request taken while busy")
  `BDA_ASSERT(a_char_range, m_axis_tvalid |-> char_ok, "character code out of range")
  `BDA_ASSERT(a_sign_not_last, sign_out |-> !m_axis_tlast, "minus sign flagged as last")
  `BDA_ASSERT(a_single_cmd, $onehot0(cmd_bits), "conflicting datapath commands")

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter testbench
// Streams 64-bit words with a signed/unsigned kind into the converter and
// checks every emitted character and its tlast flag against a built-in
// decimal formatter. Directed extremes come first, then random numbers of
// every length with random gaps on both sides, then a stretch with none.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KindUnsigned = 1'b0;
  localparam logic KindSigned   = 1'b1;

  typedef struct packed {
    logic [bda_pkg::CharW-1:0] code;
    logic                      last;
  } text_char_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [bda_pkg::ValueW-1:0]    s_axis_tdata;   // [63:0] value
  logic                          s_axis_tuser;   // [0] kind
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [bda_pkg::TdataOutW-1:0] m_axis_tdata;   // [5:0] char_code, [7:6] zero
  logic                          m_axis_tlast;   // last_char

  text_char_t pending_chars[$];
  int         errors        = 0;
  int         numbers_sent  = 0;
  int         negatives     = 0;
  int         chars_checked = 0;
  bit         no_idle       = 1'b0;

  binary_to_decimal_ascii u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #8ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Decimal text of one word, sign first, digits most significant first.
  function automatic void push_decimal_text(logic kind, logic [bda_pkg::ValueW-1:0] value);
    logic                       neg;
    logic [bda_pkg::ValueW-1:0] mag;
    logic [3:0]                 digits[bda_pkg::NumDigits];
    int                         ndig;
    text_char_t                 ch;
    neg  = (kind == KindSigned) && value[bda_pkg::ValueW-1];
    mag  = neg ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digits[ndig] = 4'(mag % 64'd10);
      mag          = mag / 64'd10;
      ndig++;
    end while (mag != 0 && ndig < bda_pkg::NumDigits);
    if (neg) begin
      ch.code = bda_pkg::CharMinus;
      ch.last = 1'b0;
      pending_chars.push_back(ch);
      negatives++;
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = bda_pkg::CharZero + bda_pkg::CharW'(digits[i]);
      ch.last = (i == 0);
      pending_chars.push_back(ch);
    end
  endfunction

  // Entered and left just after a falling edge; valid stays up between
  // back-to-back requests.
  task automatic send_number(logic kind, logic [bda_pkg::ValueW-1:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    push_decimal_text(kind, value);
    numbers_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [bda_pkg::ValueW-1:0] pow10(int n);
    logic [bda_pkg::ValueW-1:0] p;
    p = 64'd1;
    repeat (n) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [bda_pkg::ValueW-1:0] random_value();
    logic [bda_pkg::ValueW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} % pow10($urandom_range(1, 19));
      2: v = pow10($urandom_range(0, 19)) + bda_pkg::ValueW'($urandom_range(0, 2)) - 1'b1;
      3: v = bda_pkg::ValueW'($urandom_range(0, 1000));
      4: v = ~bda_pkg::ValueW'($urandom_range(0, 100000)) + 1'b1;
      default: v = {1'b1, 63'($urandom_range(0, 3))} ^ {1'($urandom_range(0, 1)), 63'd0};
    endcase
    return v;
  endfunction

  task automatic test_directed_extremes();
    send_number(KindUnsigned, 64'd0);
    send_number(KindSigned,   64'd0);
    send_number(KindUnsigned, 64'd1);
    send_number(KindUnsigned, 64'd9);
    send_number(KindUnsigned, 64'd10);
    send_number(KindSigned,   64'd99);
    send_number(KindUnsigned, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(KindSigned,   64'hFFFF_FFFF_FFFF_FFFF);
    // most negative signed word, and the same bits read as unsigned
    send_number(KindSigned,   64'h8000_0000_0000_0000);
    send_number(KindUnsigned, 64'h8000_0000_0000_0000);
    send_number(KindSigned,   64'h7FFF_FFFF_FFFF_FFFF);
    send_number(KindUnsigned, 64'h7FFF_FFFF_FFFF_FFFF);
    send_number(KindUnsigned, 64'd10000000000000000000);
    send_number(KindUnsigned, 64'd9999999999999999999);
    send_number(KindSigned,   ~64'd999999999999999999 + 1'b1);
    send_number(KindSigned,   ~64'd1000000000000000000 + 1'b1);
    send_number(KindSigned,   64'hFFFF_FFFF_FFFF_FFF6);
    send_number(KindUnsigned, 64'hAAAA_AAAA_AAAA_AAAA);
    send_number(KindSigned,   64'h5555_5555_5555_5555);
  endtask

  task automatic test_random_numbers(int count);
    repeat (count) send_number(1'($urandom_range(0, 1)), random_value());
  endtask

  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    repeat (count) send_number(1'($urandom_range(0, 1)), random_value());
    no_idle = 1'b0;
  endtask

  // Receiver: random stall ahead of every character request.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character request: tdata 0x%02h tlast %0b",
               m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata[bda_pkg::CharW-1:0] !== want.code) begin
          $error("char_code: expected %0d, got %0d", want.code,
                 m_axis_tdata[bda_pkg::CharW-1:0]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[bda_pkg::TdataOutW-1:bda_pkg::CharW] !== '0) begin
          $error("tdata pad: expected 0, got %0b",
                 m_axis_tdata[bda_pkg::TdataOutW-1:bda_pkg::CharW]);
          errors++;
        end
      end
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KindUnsigned;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_extremes();
    test_random_numbers(300);
    test_back_to_back(70);
    s_axis_tvalid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      $error("%0d characters never arrived", pending_chars.size());
      errors++;
    end

    $display("summary: %0d numbers converted (%0d negative), %0d characters checked",
             numbers_sent, negatives, chars_checked);
    $display("summary: extremes, every digit count, gaps on both sides, back-to-back");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
